>>> rtl/core/ffcu_pkg.sv
// shared constants, register indexes and helpers for the forest fire cell update unit
package ffcu_pkg;

    // cell code values
    localparam logic [7:0] CODE_EMPTY  = 8'd0;
    localparam logic [7:0] TREE_MIN    = 8'd1;
    localparam logic [7:0] TREE_MAX    = 8'd128;
    localparam logic [7:0] CODE_CLEAR  = 8'd129;
    localparam logic [7:0] GROUND_MIN  = 8'd130;
    localparam logic [7:0] GROUND_MAX  = 8'd254;
    localparam logic [7:0] CODE_BURNT  = 8'd254;
    localparam logic [7:0] CODE_FIRE   = 8'd255;

    // register indexes (paddr[2])
    localparam logic REG_LIGHTNING = 1'b0;
    localparam logic REG_IGNITE    = 1'b1;

    // register reset values (q16 fractions 0.99995 and 0.8)
    localparam logic [15:0] LIGHTNING_RESET = 16'd65533;
    localparam logic [15:0] IGNITE_RESET    = 16'd52429;

    // growth compare, scaled to integers:
    //   ground: 864000*a > (959616 - 1000*(t + c - 128)) * 2^bits
    //   empty:  768000*a > (852992 - 1000*t) * 2^bits
    localparam int GROUND_A_MUL  = 864000;
    localparam int GROUND_K_BASE = 959616;
    localparam int EMPTY_A_MUL   = 768000;
    localparam int EMPTY_K_BASE  = 852992;
    localparam int AGE_MUL       = 1000;

    // decay draw scale
    localparam int DECAY_STEPS = 10;

    // tree age of a neighbor, zero when the code is not a tree
    function automatic logic [7:0] tree_age(input logic [7:0] code);
        logic [7:0] age;
        begin
            age = ((code >= TREE_MIN) && (code <= TREE_MAX)) ? code : 8'd0;
            return age;
        end
    endfunction

endpackage

>>> rtl/core/forest_fire_cell_update_unit.sv
// forest fire automaton cell update: input register, one pass of logic, result register
// One word per cycle while results are taken: a word is captured in the input register on
// accept, the next cell code is computed in one pass of logic (neighbor age sum, growth
// compare, ignite and decay draws) and lands in the result register.
// Both stages advance together whenever the result register is empty or being taken, so
// item_ready stays high under a free-flowing output and falls only when both stages hold words.
// lightning_limit sits at byte address 0 and ignite_limit at byte address 4 of the APB port;
// write them only while no word is in flight.
module forest_fire_cell_update_unit #(
    parameter int RANDOM_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // apb configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // input word
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [7:0]             center_cell,
    input  logic [7:0]             north_west,
    input  logic [7:0]             north,
    input  logic [7:0]             north_east,
    input  logic [7:0]             west,
    input  logic [7:0]             east,
    input  logic [7:0]             south_west,
    input  logic [7:0]             south,
    input  logic [7:0]             south_east,
    input  logic [RANDOM_BITS-1:0] random_a,
    input  logic [RANDOM_BITS-1:0] random_b,
    // result word
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [7:0]             next_cell
);

    localparam int CMP_W  = (RANDOM_BITS > 16) ? RANDOM_BITS : 16;
    localparam int K_W    = 23;
    localparam int PROD_W = RANDOM_BITS + K_W;
    localparam int DEC_W  = RANDOM_BITS + 4;

    // configuration registers
    logic [15:0] lightning_limit_reg;
    logic [15:0] ignite_limit_reg;
    logic        cfg_write;

    // input stage
    logic                   s1_valid_reg;
    logic [7:0]             s1_center_reg;
    logic [7:0]             s1_nbr_reg [8];
    logic [RANDOM_BITS-1:0] s1_random_a_reg;
    logic [RANDOM_BITS-1:0] s1_random_b_reg;

    // result stage
    logic       result_valid_reg;
    logic [7:0] result_reg;
    logic [7:0] result_next;

    // handshake
    logic advance;
    logic item_accept;

    // compute signals
    logic [10:0]              trees;
    logic                     fire_near;
    logic                     strike;
    logic                     ignite;
    logic signed [K_W-1:0]    trees_s;
    logic signed [K_W-1:0]    center_s;
    logic signed [K_W-1:0]    k_ground;
    logic signed [K_W-1:0]    k_empty;
    logic signed [PROD_W-1:0] ra_ext;
    logic signed [PROD_W-1:0] lhs_ground;
    logic signed [PROD_W-1:0] lhs_empty;
    logic signed [PROD_W-1:0] rhs_ground;
    logic signed [PROD_W-1:0] rhs_empty;
    logic                     grow_ground;
    logic                     grow_empty;
    logic [DEC_W-1:0]         decay_prod;
    logic [3:0]               decay;
    logic [7:0]               decayed;

    // apb access, always ready
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = 32'd0;
        case (paddr[2])
            ffcu_pkg::REG_LIGHTNING: prdata = {16'd0, lightning_limit_reg};
            ffcu_pkg::REG_IGNITE:    prdata = {16'd0, ignite_limit_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lightning_limit_reg <= ffcu_pkg::LIGHTNING_RESET;
            ignite_limit_reg    <= ffcu_pkg::IGNITE_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                ffcu_pkg::REG_LIGHTNING: lightning_limit_reg <= pwdata[15:0];
                ffcu_pkg::REG_IGNITE:    ignite_limit_reg    <= pwdata[15:0];
                default:                 ;
            endcase
        end
    end

    // pipeline advance: result slot free or being taken
    assign advance      = !result_valid_reg || result_ready;
    assign item_ready   = !s1_valid_reg || advance;
    assign item_accept  = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign next_cell    = result_reg;

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_center_reg   <= center_cell;
            s1_nbr_reg[0]   <= north_west;
            s1_nbr_reg[1]   <= north;
            s1_nbr_reg[2]   <= north_east;
            s1_nbr_reg[3]   <= west;
            s1_nbr_reg[4]   <= east;
            s1_nbr_reg[5]   <= south_west;
            s1_nbr_reg[6]   <= south;
            s1_nbr_reg[7]   <= south_east;
            s1_random_a_reg <= random_a;
            s1_random_b_reg <= random_b;
        end
    end

    // neighbor tree age sum and burning neighbor flag
    always_comb
    begin
        trees     = 11'd0;
        fire_near = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            trees     = trees + 11'(ffcu_pkg::tree_age(s1_nbr_reg[i]));
            fire_near = fire_near || (s1_nbr_reg[i] == ffcu_pkg::CODE_FIRE);
        end
    end

    // lightning and ignite draws
    assign strike = CMP_W'(s1_random_a_reg) > CMP_W'(lightning_limit_reg);
    assign ignite = (strike || fire_near) &&
                    (CMP_W'(s1_random_b_reg) < CMP_W'(ignite_limit_reg));

    // growth thresholds, may go negative
    assign trees_s  = K_W'(trees);
    assign center_s = K_W'(s1_center_reg);
    assign k_ground = K_W'(ffcu_pkg::GROUND_K_BASE)
                    - K_W'(ffcu_pkg::AGE_MUL)
                    * (trees_s + center_s - K_W'(ffcu_pkg::TREE_MAX));
    assign k_empty  = K_W'(ffcu_pkg::EMPTY_K_BASE) - K_W'(ffcu_pkg::AGE_MUL) * trees_s;

    // signed growth compares, threshold scaled by 2^bits
    assign ra_ext      = PROD_W'(s1_random_a_reg);
    assign lhs_ground  = ra_ext * PROD_W'(ffcu_pkg::GROUND_A_MUL);
    assign lhs_empty   = ra_ext * PROD_W'(ffcu_pkg::EMPTY_A_MUL);
    assign rhs_ground  = PROD_W'(k_ground) <<< RANDOM_BITS;
    assign rhs_empty   = PROD_W'(k_empty) <<< RANDOM_BITS;
    assign grow_ground = lhs_ground > rhs_ground;
    assign grow_empty  = lhs_empty > rhs_empty;

    // ground decay, floor(b * 10 / 2^bits), floored at the clear code
    assign decay_prod = DEC_W'(s1_random_b_reg) * DEC_W'(ffcu_pkg::DECAY_STEPS);
    assign decay      = decay_prod[DEC_W-1:RANDOM_BITS];
    assign decayed    = s1_center_reg - {4'd0, decay};

    // next cell code
    always_comb
    begin
        result_next = ffcu_pkg::CODE_EMPTY;
        case (s1_center_reg) inside
            ffcu_pkg::CODE_FIRE:
                result_next = ffcu_pkg::CODE_BURNT;
            [ffcu_pkg::TREE_MIN:ffcu_pkg::TREE_MAX]:
            begin
                if (ignite)
                    result_next = ffcu_pkg::CODE_FIRE;
                else if (s1_center_reg == ffcu_pkg::TREE_MAX)
                    result_next = ffcu_pkg::TREE_MAX;
                else
                    result_next = s1_center_reg + 8'd1;
            end
            ffcu_pkg::CODE_CLEAR:
                result_next = ffcu_pkg::CODE_EMPTY;
            [ffcu_pkg::GROUND_MIN:ffcu_pkg::GROUND_MAX]:
            begin
                if (grow_ground)
                    result_next = ffcu_pkg::TREE_MIN;
                else if (decayed < ffcu_pkg::CODE_CLEAR)
                    result_next = ffcu_pkg::CODE_CLEAR;
                else
                    result_next = decayed;
            end
            default:
                result_next = grow_empty ? ffcu_pkg::TREE_MIN : ffcu_pkg::CODE_EMPTY;
        endcase
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // stall only when both stages hold words
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (s1_valid_reg && result_valid_reg))
        else $error("input stalled with a free stage");

    // fire always burns out to ground
    a_fire_burns: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_valid_reg && s1_center_reg == ffcu_pkg::CODE_FIRE)
        |=> (result_reg == ffcu_pkg::CODE_BURNT))
        else $error("fire did not turn into burnt ground");

    // cleared ground goes empty
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_valid_reg && s1_center_reg == ffcu_pkg::CODE_CLEAR)
        |=> (result_reg == ffcu_pkg::CODE_EMPTY))
        else $error("clear code did not go empty");

    // a tree stays a tree or catches fire
    a_tree_next: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_valid_reg && s1_center_reg >= ffcu_pkg::TREE_MIN
            && s1_center_reg <= ffcu_pkg::TREE_MAX)
        |=> ((result_reg >= ffcu_pkg::TREE_MIN && result_reg <= ffcu_pkg::TREE_MAX)
            || result_reg == ffcu_pkg::CODE_FIRE))
        else $error("tree update out of range");

    // a lightning limit write lands
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && paddr[2] == ffcu_pkg::REG_LIGHTNING)
        |=> (lightning_limit_reg == $past(pwdata[15:0])))
        else $error("lightning limit write lost");

endmodule

>>> sim/tb_forest_fire_cell_update_unit.sv
// testbench for the forest fire cell update unit: directed and random cell words, apb setup
module tb_forest_fire_cell_update_unit;

    localparam int RBITS       = 16;
    localparam int QUIET_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_WORDS = 235;

    // register defaults after reset
    localparam logic [15:0] LIGHTNING_DEFAULT = 16'd65533;
    localparam logic [15:0] IGNITE_DEFAULT    = 16'd52429;

    // growth compare scaled to integers
    localparam longint GROUND_DRAW_MUL = 864000;
    localparam longint GROUND_BASE     = 959616;
    localparam longint EMPTY_DRAW_MUL  = 768000;
    localparam longint EMPTY_BASE      = 852992;
    localparam longint AGE_WEIGHT      = 1000;
    localparam longint DECAY_SCALE     = 10;

    typedef struct packed {
        logic [7:0]       center;
        logic [7:0]       nw;
        logic [7:0]       n;
        logic [7:0]       ne;
        logic [7:0]       w;
        logic [7:0]       e;
        logic [7:0]       sw;
        logic [7:0]       s;
        logic [7:0]       se;
        logic [RBITS-1:0] ra;
        logic [RBITS-1:0] rb;
    } cell_word_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN
    } stall_mode_t;

    // clock, reset and block ports
    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             psel         = 1'b0;
    logic             penable      = 1'b0;
    logic             pwrite       = 1'b0;
    logic [2:0]       paddr        = '0;
    logic [31:0]      pwdata       = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    logic             result_valid;
    logic             result_ready = 1'b0;
    logic [7:0]       next_cell;
    cell_word_t       word_q       = '0;

    // testbench state
    logic [15:0]      lightning_cfg = LIGHTNING_DEFAULT;
    logic [15:0]      ignite_cfg    = IGNITE_DEFAULT;
    logic [7:0]       expected_cells[$];
    int               mismatch_count = 0;
    int               quiet_cycles   = 0;
    stall_mode_t      stall_mode     = STALL_NONE;
    logic [15:0]      stall_pattern  = 16'hffff;
    logic [3:0]       pattern_pos    = '0;
    int               stall_run      = 0;
    bit               gaps_enabled   = 1'b0;
    int               burst_left     = 0;

    forest_fire_cell_update_unit #(
        .RANDOM_BITS (RBITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .center_cell  (word_q.center),
        .north_west   (word_q.nw),
        .north        (word_q.n),
        .north_east   (word_q.ne),
        .west         (word_q.w),
        .east         (word_q.e),
        .south_west   (word_q.sw),
        .south        (word_q.s),
        .south_east   (word_q.se),
        .random_a     (word_q.ra),
        .random_b     (word_q.rb),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .next_cell    (next_cell)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // next cell code for one word under the current limits
    function automatic logic [7:0] next_cell_code(input cell_word_t cw);
        logic [7:0] nbrs[8];
        longint     age_sum;
        bit         burning_near;
        longint     draw_lhs;
        longint     threshold;
        longint     decay;
        longint     decayed;
        logic [7:0] code;
        begin
            nbrs = '{cw.nw, cw.n, cw.ne, cw.w, cw.e, cw.sw, cw.s, cw.se};
            age_sum = 0;
            burning_near = 1'b0;
            foreach (nbrs[i])
            begin
                if (nbrs[i] >= ffcu_pkg::TREE_MIN && nbrs[i] <= ffcu_pkg::TREE_MAX)
                    age_sum += longint'(nbrs[i]);
                if (nbrs[i] == ffcu_pkg::CODE_FIRE)
                    burning_near = 1'b1;
            end
            if (cw.center == ffcu_pkg::CODE_FIRE)
                code = ffcu_pkg::CODE_BURNT;
            else if (cw.center >= ffcu_pkg::TREE_MIN && cw.center <= ffcu_pkg::TREE_MAX)
            begin
                // tree: strike or spread gated by the ignite draw, else age
                if ((cw.ra > lightning_cfg || burning_near) && cw.rb < ignite_cfg)
                    code = ffcu_pkg::CODE_FIRE;
                else if (cw.center == ffcu_pkg::TREE_MAX)
                    code = ffcu_pkg::TREE_MAX;
                else
                    code = cw.center + 8'd1;
            end
            else if (cw.center == ffcu_pkg::CODE_CLEAR)
                code = ffcu_pkg::CODE_EMPTY;
            else if (cw.center >= ffcu_pkg::GROUND_MIN)
            begin
                // burned ground: signed growth compare, else decay toward clear
                draw_lhs  = GROUND_DRAW_MUL * longint'(cw.ra);
                threshold = GROUND_BASE
                            - AGE_WEIGHT * (age_sum + longint'(cw.center) - 128);
                if (draw_lhs > threshold * (longint'(1) <<< RBITS))
                    code = ffcu_pkg::TREE_MIN;
                else
                begin
                    decay   = (longint'(cw.rb) * DECAY_SCALE) >>> RBITS;
                    decayed = longint'(cw.center) - decay;
                    code    = (decayed < longint'(ffcu_pkg::CODE_CLEAR))
                              ? ffcu_pkg::CODE_CLEAR : decayed[7:0];
                end
            end
            else
            begin
                // empty ground: growth from neighbor ages only
                draw_lhs  = EMPTY_DRAW_MUL * longint'(cw.ra);
                threshold = EMPTY_BASE - AGE_WEIGHT * age_sum;
                code = (draw_lhs > threshold * (longint'(1) <<< RBITS))
                       ? ffcu_pkg::TREE_MIN : ffcu_pkg::CODE_EMPTY;
            end
            return code;
        end
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int act_val);
        begin
            if (mismatch_count < MAX_REPORTS)
                $display("mismatch %s: expected %0d actual %0d at %0t",
                         what, exp_val, act_val, $realtime);
            mismatch_count++;
        end
    endtask

    // result checking, prediction on accept, idle cycle count
    always @(posedge clk)
    begin
        logic [7:0] want;
        bit         moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                moved = 1'b1;
                if (expected_cells.size() == 0)
                    report_mismatch("unexpected word next_cell", -1, next_cell);
                else
                begin
                    want = expected_cells.pop_front();
                    if (next_cell !== want)
                        report_mismatch("next_cell", want, next_cell);
                end
            end
            if (item_valid && item_ready)
            begin
                moved = 1'b1;
                expected_cells.push_back(next_cell_code(word_q));
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    // watchdog on cycles with no word moving
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // receiver back pressure
    always @(posedge clk)
    begin
        pattern_pos <= pattern_pos + 4'd1;
        case (stall_mode)
            STALL_NONE:
                result_ready <= 1'b1;
            STALL_PATTERN:
                result_ready <= stall_pattern[pattern_pos];
            default:
            begin
                if (stall_run > 0)
                begin
                    result_ready <= 1'b0;
                    stall_run <= stall_run - 1;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    result_ready <= 1'b0;
                    stall_run <= $urandom_range(0, 12);
                end
                else
                    result_ready <= 1'b1;
            end
        endcase
    end

    // apb write, model limits follow the register
    task automatic write_reg(input logic idx, input logic [31:0] value);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= value;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            if (idx == ffcu_pkg::REG_LIGHTNING)
                lightning_cfg = value[15:0];
            else
                ignite_cfg = value[15:0];
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
        end
    endtask

    // apb read, checked against the model
    task automatic check_reg(input logic idx);
        logic [15:0] want;
        begin
            want = (idx == ffcu_pkg::REG_LIGHTNING) ? lightning_cfg : ignite_cfg;
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {idx, 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            if (prdata[15:0] !== want)
                report_mismatch(idx == ffcu_pkg::REG_LIGHTNING ? "lightning_limit"
                                                               : "ignite_limit",
                                want, prdata[15:0]);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic set_limits(input logic [15:0] lightning, input logic [15:0] ignite);
        begin
            write_reg(ffcu_pkg::REG_LIGHTNING, {16'($urandom), lightning});
            write_reg(ffcu_pkg::REG_IGNITE, {16'($urandom), ignite});
        end
    endtask

    // present one word and hold it until accepted
    task automatic send_word(input cell_word_t cw);
        begin
            word_q     <= cw;
            item_valid <= 1'b1;
            @(posedge clk);
            while (!item_ready) @(posedge clk);
        end
    endtask

    task automatic idle_sender(input int cycles);
        begin
            if (cycles > 0)
            begin
                item_valid <= 1'b0;
                repeat (cycles) @(posedge clk);
            end
        end
    endtask

    // bursts of random length with random gaps between them
    task automatic send_paced(input cell_word_t cw);
        begin
            if (gaps_enabled && burst_left == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    idle_sender($urandom_range(8, 24));
                else
                    idle_sender($urandom_range(0, 6));
                burst_left = $urandom_range(1, 16);
            end
            send_word(cw);
            if (burst_left > 0)
                burst_left--;
        end
    endtask

    // stop sending and let every expected word come back
    task automatic wait_drained();
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while (expected_cells.size() != 0) @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    function automatic cell_word_t set_neighbor(input cell_word_t cw, input int pos,
                                                input logic [7:0] code);
        begin
            case (pos)
                0: cw.nw = code;
                1: cw.n  = code;
                2: cw.ne = code;
                3: cw.w  = code;
                4: cw.e  = code;
                5: cw.sw = code;
                6: cw.s  = code;
                default: cw.se = code;
            endcase
            return cw;
        end
    endfunction

    function automatic cell_word_t uniform_word(input logic [7:0] center,
                                                input logic [7:0] nbr,
                                                input logic [RBITS-1:0] ra,
                                                input logic [RBITS-1:0] rb);
        cell_word_t cw;
        begin
            cw.center = center;
            cw.ra     = ra;
            cw.rb     = rb;
            for (int i = 0; i < 8; i++)
                cw = set_neighbor(cw, i, nbr);
            return cw;
        end
    endfunction

    // neighbor codes biased toward trees and fire
    function automatic logic [7:0] random_neighbor();
        int pick;
        begin
            pick = $urandom_range(0, 19);
            if (pick < 10)
                return (pick == 0) ? ffcu_pkg::TREE_MAX : 8'($urandom_range(1, 128));
            else if (pick < 12)
                return ffcu_pkg::CODE_FIRE;
            else if (pick < 15)
                return ffcu_pkg::CODE_EMPTY;
            else if (pick < 18)
                return 8'($urandom_range(129, 254));
            else
                return 8'($urandom);
        end
    endfunction

    // draws land near a limit or at an extreme now and then
    function automatic logic [RBITS-1:0] random_draw(input logic [15:0] limit);
        int pick;
        begin
            pick = $urandom_range(0, 15);
            if (pick < 2)
                return limit + RBITS'($urandom_range(0, 2)) - RBITS'(1);
            else if (pick == 2)
                return '0;
            else if (pick == 3)
                return '1;
            else
                return RBITS'($urandom);
        end
    endfunction

    function automatic cell_word_t random_word();
        cell_word_t cw;
        int         pick;
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       cw.center = ffcu_pkg::CODE_FIRE;
                1, 2:    cw.center = 8'($urandom_range(1, 128));
                3:       cw.center = ($urandom_range(0, 1) != 0) ? ffcu_pkg::TREE_MAX
                                                                 : ffcu_pkg::TREE_MIN;
                4:       cw.center = ffcu_pkg::CODE_CLEAR;
                5, 6:    cw.center = 8'($urandom_range(130, 254));
                7:       cw.center = 8'($urandom);
                default: cw.center = ffcu_pkg::CODE_EMPTY;
            endcase
            for (int i = 0; i < 8; i++)
                cw = set_neighbor(cw, i, random_neighbor());
            cw.ra = random_draw(lightning_cfg);
            cw.rb = random_draw(ignite_cfg);
            return cw;
        end
    endfunction

    // registers come up at their defaults and hold what is written
    task automatic test_registers();
        begin
            check_reg(ffcu_pkg::REG_LIGHTNING);
            check_reg(ffcu_pkg::REG_IGNITE);
            set_limits(16'h0000, 16'hffff);
            check_reg(ffcu_pkg::REG_LIGHTNING);
            check_reg(ffcu_pkg::REG_IGNITE);
            set_limits(16'hffff, 16'h0000);
            check_reg(ffcu_pkg::REG_LIGHTNING);
            check_reg(ffcu_pkg::REG_IGNITE);
            set_limits(16'($urandom), 16'($urandom));
            check_reg(ffcu_pkg::REG_LIGHTNING);
            check_reg(ffcu_pkg::REG_IGNITE);
            set_limits(LIGHTNING_DEFAULT, IGNITE_DEFAULT);
        end
    endtask

    // each cell rule and boundary at the default limits
    task automatic test_cell_rules();
        cell_word_t cw;
        begin
            stall_mode <= STALL_NONE;
            gaps_enabled = 1'b0;
            send_word(uniform_word(ffcu_pkg::CODE_FIRE, ffcu_pkg::CODE_EMPTY, '0, '0));
            send_word(uniform_word(8'hff, 8'hff, '1, '1));
            send_word(uniform_word(8'h00, 8'h00, '0, '0));
            // lightning just above and at the limit
            send_word(uniform_word(ffcu_pkg::TREE_MIN, ffcu_pkg::CODE_EMPTY, '1, '0));
            send_word(uniform_word(ffcu_pkg::TREE_MIN, ffcu_pkg::CODE_EMPTY,
                                   LIGHTNING_DEFAULT, '0));
            // fire spread from each neighbor position
            for (int i = 0; i < 8; i++)
                send_word(set_neighbor(uniform_word(8'd50, 8'd20, '0, '0), i,
                                       ffcu_pkg::CODE_FIRE));
            // ignite draw at and just below the limit
            cw = set_neighbor(uniform_word(8'd50, ffcu_pkg::CODE_EMPTY, '0, IGNITE_DEFAULT),
                              0, ffcu_pkg::CODE_FIRE);
            send_word(cw);
            cw.rb = IGNITE_DEFAULT - 16'd1;
            send_word(cw);
            // full-grown tree stays, or burns
            send_word(uniform_word(ffcu_pkg::TREE_MAX, ffcu_pkg::CODE_EMPTY, '0, '0));
            send_word(uniform_word(ffcu_pkg::TREE_MAX, ffcu_pkg::CODE_EMPTY, '1, '0));
            send_word(uniform_word(ffcu_pkg::CODE_CLEAR, ffcu_pkg::TREE_MAX, '1, '1));
            // decay clamps at clear, decay draw step edge
            send_word(uniform_word(ffcu_pkg::GROUND_MIN, ffcu_pkg::CODE_EMPTY, '0, '1));
            send_word(uniform_word(ffcu_pkg::GROUND_MAX, ffcu_pkg::CODE_EMPTY, '0, '1));
            send_word(uniform_word(8'd200, ffcu_pkg::CODE_EMPTY, '0, 16'd6553));
            send_word(uniform_word(8'd200, ffcu_pkg::CODE_EMPTY, '0, 16'd6554));
            // negative growth threshold sprouts even with a zero draw
            send_word(uniform_word(ffcu_pkg::GROUND_MAX, ffcu_pkg::TREE_MAX, '0, '1));
            send_word(uniform_word(ffcu_pkg::CODE_EMPTY, ffcu_pkg::TREE_MAX, '0, '0));
            send_word(uniform_word(ffcu_pkg::CODE_EMPTY, 8'd100, '1, '0));
            send_word(uniform_word(ffcu_pkg::CODE_EMPTY, ffcu_pkg::CODE_CLEAR, '1, '1));
            wait_drained();
        end
    endtask

    // random grid words under one limit setting and one idling style
    task automatic test_random_grid(input logic [15:0] lightning, input logic [15:0] ignite,
                                    input stall_mode_t mode, input bit gaps);
        begin
            set_limits(lightning, ignite);
            check_reg(ffcu_pkg::REG_LIGHTNING);
            check_reg(ffcu_pkg::REG_IGNITE);
            stall_mode    <= mode;
            stall_pattern <= 16'($urandom) | 16'h0001;
            gaps_enabled  = gaps;
            burst_left    = 0;
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                // sender holds off until the pipe is empty
                if (i == PHASE_WORDS / 2)
                    wait_drained();
                send_paced(random_word());
            end
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_registers();
        test_cell_rules();
        test_random_grid(LIGHTNING_DEFAULT, IGNITE_DEFAULT, STALL_NONE, 1'b0);
        test_random_grid(16'h0000, 16'hffff, STALL_RANDOM, 1'b1);
        test_random_grid(16'hffff, 16'h0000, STALL_PATTERN, 1'b1);
        test_random_grid(16'($urandom_range(60000, 65535)), 16'($urandom),
                         STALL_RANDOM, 1'b1);
        test_random_grid(16'($urandom), 16'($urandom), STALL_PATTERN, 1'b0);

        // settle after the last word
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
